>>> hdl/sctb_pkg.sv
// Shared types and constants for the settable clock with debounced set buttons.
// No dependencies; imported by every module of the block.
package sctb_pkg;

  localparam int BUTTON_COUNT = 3;

  // Button roles by lane index
  localparam int BTN_MINUTE = 0;
  localparam int BTN_HOUR   = 1;
  localparam int BTN_BRIGHT = 2;

  // Time-of-day limits
  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [6:0] MIN_MODULO = 7'd60;
  localparam logic [5:0] HOUR_MODULO = 6'd24;
  localparam logic [1:0] STAGE_RESET = 2'd2;

  // Register reset values
  localparam logic [9:0]  DEBOUNCE_RESET   = 10'd50;
  localparam logic [15:0] SHORT_HOLD_RESET = 16'd100;
  localparam logic [15:0] LONG_HOLD_RESET  = 16'd2000;
  localparam logic [15:0] REPEAT_RESET     = 16'd50;
  localparam logic [7:0]  LEVEL0_RESET     = 8'd254;
  localparam logic [7:0]  LEVEL1_RESET     = 8'd248;
  localparam logic [7:0]  LEVEL2_RESET     = 8'd156;
  localparam logic [7:0]  LEVEL3_RESET     = 8'd0;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_SHORT_HOLD = 3'd1,
    REG_LONG_HOLD  = 3'd2,
    REG_REPEAT     = 3'd3,
    REG_LEVEL0     = 3'd4,
    REG_LEVEL1     = 3'd5,
    REG_LEVEL2     = 3'd6,
    REG_LEVEL3     = 3'd7
  } reg_idx_t;

  // Hold and debounce settings shared by all lanes
  typedef struct packed {
    logic [9:0]  debounce_len;
    logic [15:0] short_hold_ticks;
    logic [15:0] long_hold_ticks;
    logic [15:0] repeat_interval;
  } hold_cfg_t;

  // What one button lane found during a sample step
  typedef struct packed {
    logic short_press;
    logic repeat_step;
    logic force_zero;
  } lane_evt_t;

endpackage

>>> hdl/sctb_lane.sv
// One button lane: integrating debounce, hold counter, hold flags, repeat phase.
// Depends on sctb_pkg (hold_cfg_t, lane_evt_t).
module sctb_lane import sctb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step_en,
  input  logic      raw,
  input  logic      repeat_en,
  input  hold_cfg_t cfg,
  output logic      pressed,
  output logic      pressed_upd,
  output lane_evt_t evt
);

  logic [9:0]  integrator, integrator_next;
  logic [15:0] hold_count, hold_count_next;
  logic        short_flag, short_flag_next;
  logic        long_flag, long_flag_next;
  logic [15:0] repeat_phase, repeat_phase_next;
  logic        pressed_next;
  logic        short_press;

  logic [9:0]  integ_up, integ_dn;
  logic [15:0] hold_inc;
  logic [16:0] phase_inc;

  assign integ_up  = (integrator < cfg.debounce_len) ? integrator + 10'd1 : integrator;
  assign integ_dn  = (integrator != 10'd0) ? integrator - 10'd1 : integrator;
  assign hold_inc  = hold_count + 16'd1;
  assign phase_inc = {1'b0, repeat_phase} + 17'd1;

  // Sample step
  always_comb begin
    integrator_next   = integrator;
    hold_count_next   = hold_count;
    short_flag_next   = short_flag;
    long_flag_next    = long_flag;
    repeat_phase_next = repeat_phase;
    pressed_next      = pressed;
    short_press       = 1'b0;
    if (raw) begin
      integrator_next = integ_up;
      if (integ_up >= cfg.debounce_len) begin
        if (!pressed) begin
          pressed_next      = 1'b1;
          hold_count_next   = '0;
          short_flag_next   = 1'b0;
          long_flag_next    = 1'b0;
          repeat_phase_next = '0;
        end else begin
          hold_count_next = hold_inc;
          // phase tracks hold_count mod interval, restarting on timer wrap
          if (hold_inc == 16'd0) begin
            repeat_phase_next = '0;
          end else if (phase_inc >= {1'b0, cfg.repeat_interval}) begin
            repeat_phase_next = '0;
          end else begin
            repeat_phase_next = phase_inc[15:0];
          end
          if (hold_inc == cfg.short_hold_ticks) short_flag_next = 1'b1;
          if (hold_inc == cfg.long_hold_ticks)  long_flag_next  = 1'b1;
        end
      end
    end else begin
      integrator_next = integ_dn;
      if (integ_dn == 10'd0 && pressed) begin
        pressed_next    = 1'b0;
        short_press     = !short_flag && !long_flag;
        short_flag_next = 1'b0;
        long_flag_next  = 1'b0;
      end
    end
  end

  // Events seen by the merge stage, only on a sample step
  always_comb begin
    evt.short_press = step_en && short_press;
    evt.repeat_step = step_en && repeat_en && pressed_next && short_flag_next &&
                      (repeat_phase_next == 16'd0);
    evt.force_zero  = step_en && pressed_next && long_flag_next;
    pressed_upd     = step_en ? pressed_next : pressed;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed      <= 1'b0;
      integrator   <= '0;
      hold_count   <= '0;
      short_flag   <= 1'b0;
      long_flag    <= 1'b0;
      repeat_phase <= '0;
    end else if (step_en) begin
      pressed      <= pressed_next;
      integrator   <= integrator_next;
      hold_count   <= hold_count_next;
      short_flag   <= short_flag_next;
      long_flag    <= long_flag_next;
      repeat_phase <= repeat_phase_next;
    end
  end

endmodule

>>> hdl/sctb_time.sv
// Merge stage: time-of-day counter and brightness stage, driven by lane events.
// Depends on sctb_pkg (lane_evt_t, button roles, time limits).
module sctb_time import sctb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step_en,
  input  logic        second_tick,
  input  lane_evt_t   evt [BUTTON_COUNT],
  output logic [4:0]  hour_next,
  output logic [5:0]  minute_next,
  output logic [5:0]  second_next,
  output logic [1:0]  stage_next
);

  logic [4:0] hour_count;
  logic [5:0] min_count;
  logic [5:0] sec_count;
  logic [1:0] bright_stage;

  logic       sec_wrap, min_step, hour_step, min_carry;
  logic [6:0] min_sum;
  logic [5:0] hour_sum;

  // Second tick first, then at most one minute step and one hour step
  always_comb begin
    sec_wrap  = second_tick && (sec_count == SEC_LAST);
    min_step  = evt[BTN_MINUTE].short_press || evt[BTN_MINUTE].repeat_step;
    hour_step = evt[BTN_HOUR].short_press || evt[BTN_HOUR].repeat_step;

    min_sum   = {1'b0, min_count} + {6'd0, sec_wrap} + {6'd0, min_step};
    min_carry = (min_sum >= MIN_MODULO);
    minute_next = min_carry ? 6'(min_sum - MIN_MODULO) : min_sum[5:0];

    if (min_step) begin
      second_next = '0;
    end else if (second_tick) begin
      second_next = sec_wrap ? 6'd0 : sec_count + 6'd1;
    end else begin
      second_next = sec_count;
    end

    hour_sum  = {1'b0, hour_count} + {5'd0, min_carry} + {5'd0, hour_step};
    hour_next = (hour_sum >= HOUR_MODULO) ? 5'(hour_sum - HOUR_MODULO) : hour_sum[4:0];
  end

  // Brightness: cycle on a short press, forced low by a long hold
  always_comb begin
    priority if (evt[BTN_BRIGHT].force_zero) begin
      stage_next = 2'd0;
    end else if (evt[BTN_BRIGHT].short_press) begin
      stage_next = bright_stage + 2'd1;
    end else begin
      stage_next = bright_stage;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count   <= '0;
      min_count    <= '0;
      sec_count    <= '0;
      bright_stage <= STAGE_RESET;
    end else if (step_en) begin
      hour_count   <= hour_next;
      min_count    <= minute_next;
      sec_count    <= second_next;
      bright_stage <= stage_next;
    end
  end

endmodule

>>> hdl/settable_clock_with_button_hold.sv
// Top level: register port, three button lanes, merge stage, result register.
// Depends on sctb_pkg, sctb_lane and sctb_time.
//
//  channel  | handshake                     | payload
//  item     | item_valid / item_ready       | second_tick, sample_tick, buttons_raw
//  result   | result_valid / result_ready   | hour_now .. buttons_debounced
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One item per cycle while ready: all state updates in the cycle of the
// transfer, the result is held in one output register. item_ready drops only while
// that register is full and not being taken. Results follow in the next cycle.
// Synchronous reset clears time to 00:00:00, stage 2, all button state and
// restores the register defaults; no clearing pass is needed.
module settable_clock_with_button_hold import sctb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        second_tick,
  input  logic        sample_tick,
  input  logic [2:0]  buttons_raw,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [4:0]  hour_now,
  output logic [5:0]  minute_now,
  output logic [5:0]  second_now,
  output logic [1:0]  stage_now,
  output logic [7:0]  pwm_level,
  output logic [2:0]  buttons_debounced,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hold_cfg_t cfg;
  logic [7:0] level [4];
  logic       reg_write;
  reg_idx_t   reg_idx;

  logic       accept, sample_en;
  lane_evt_t  evt [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] pressed_vec, pressed_upd;

  logic [4:0] hour_next;
  logic [5:0] minute_next, second_next;
  logic [1:0] stage_next;

  // Register port
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_len     <= DEBOUNCE_RESET;
      cfg.short_hold_ticks <= SHORT_HOLD_RESET;
      cfg.long_hold_ticks  <= LONG_HOLD_RESET;
      cfg.repeat_interval  <= REPEAT_RESET;
      level[0]             <= LEVEL0_RESET;
      level[1]             <= LEVEL1_RESET;
      level[2]             <= LEVEL2_RESET;
      level[3]             <= LEVEL3_RESET;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   cfg.debounce_len     <= pwdata[9:0];
        REG_SHORT_HOLD: cfg.short_hold_ticks <= pwdata[15:0];
        REG_LONG_HOLD:  cfg.long_hold_ticks  <= pwdata[15:0];
        REG_REPEAT:     cfg.repeat_interval  <= pwdata[15:0];
        REG_LEVEL0:     level[0]             <= pwdata[7:0];
        REG_LEVEL1:     level[1]             <= pwdata[7:0];
        REG_LEVEL2:     level[2]             <= pwdata[7:0];
        REG_LEVEL3:     level[3]             <= pwdata[7:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   prdata = {22'd0, cfg.debounce_len};
      REG_SHORT_HOLD: prdata = {16'd0, cfg.short_hold_ticks};
      REG_LONG_HOLD:  prdata = {16'd0, cfg.long_hold_ticks};
      REG_REPEAT:     prdata = {16'd0, cfg.repeat_interval};
      REG_LEVEL0:     prdata = {24'd0, level[0]};
      REG_LEVEL1:     prdata = {24'd0, level[1]};
      REG_LEVEL2:     prdata = {24'd0, level[2]};
      REG_LEVEL3:     prdata = {24'd0, level[3]};
    endcase
  end

  // Item transfer
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign sample_en  = accept && sample_tick;

  // Button lanes
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    sctb_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .step_en     (sample_en),
      .raw         (buttons_raw[g]),
      .repeat_en   (g != BTN_BRIGHT),
      .cfg         (cfg),
      .pressed     (pressed_vec[g]),
      .pressed_upd (pressed_upd[g]),
      .evt         (evt[g])
    );
  end

  // Merge stage
  sctb_time u_time (
    .clk         (clk),
    .rst         (rst),
    .step_en     (accept),
    .second_tick (second_tick),
    .evt         (evt),
    .hour_next   (hour_next),
    .minute_next (minute_next),
    .second_next (second_next),
    .stage_next  (stage_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hour_now          <= hour_next;
      minute_now        <= minute_next;
      second_now        <= second_next;
      stage_now         <= stage_next;
      pwm_level         <= level[stage_next];
      buttons_debounced <= pressed_upd;
    end
  end

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item_ready low with empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("transfer did not produce a result");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hour_now < 5'd24 && minute_now < 6'd60 && second_now < 6'd60))
    else $error("time field out of range");

  a_no_sample_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !sample_tick) |=> (pressed_vec == $past(pressed_vec)))
    else $error("button state changed without a sample tick");

endmodule
